/* sv/two_gate_speed_trap_macros.svh */
// assertion macros for the two-gate speed trap
// used by the top level; depends on nothing
`ifndef TWO_GATE_SPEED_TRAP_MACROS_SVH
`define TWO_GATE_SPEED_TRAP_MACROS_SVH

// same-cycle implication, checked outside reset
`define TGST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("speed trap check failed");

// next-cycle implication, checked outside reset
`define TGST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("speed trap check failed");

`endif

/* sv/tgst_pkg.sv */
// shared types and constants of the two-gate speed trap
// used by tgst_div, two_gate_speed_trap and two_gate_speed_trap_test; depends on nothing
package tgst_pkg;

  localparam int unsigned TOUT_W   = 16;
  localparam int unsigned TPM_W    = 8;
  localparam int unsigned DIST_W   = 8;
  localparam int unsigned LIM_W    = 7;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned WHOLE_W  = 18;
  localparam int unsigned TENTH_W  = 4;
  localparam int unsigned CFG_DW   = 16;
  localparam int unsigned CFG_AW   = 2;
  // ten times a remainder below 2^16 needs 20 bits
  localparam int unsigned NUM_MIN_W = 20;

  localparam logic [TOUT_W-1:0] TOUT_RST = 16'd62500;
  localparam logic [TPM_W-1:0]  TPM_RST  = 8'd15;
  localparam logic [DIST_W-1:0] DIST_RST = 8'd10;
  localparam logic [LIM_W-1:0]  LIM_RST  = 7'd0;
  localparam logic [MS_W-1:0]   MS_MAX   = 16'hFFFF;
  localparam logic [9:0]        WHOLE_SCALE = 10'd1000;
  localparam logic [3:0]        TENTH_SCALE = 4'd10;

  typedef enum logic [CFG_AW-1:0] {
    CFG_TIMEOUT = 2'd0,
    CFG_TPM     = 2'd1,
    CFG_DIST    = 2'd2,
    CFG_LIMIT   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* sv/tgst_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
// depends on tgst_pkg
module tgst_div import tgst_pkg::*; #(
  parameter int unsigned DW = 20,
  parameter int unsigned VW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output div_stat_t     stat_o,
  output logic [DW-1:0] quotient_o,
  output logic [VW-1:0] remainder_o
);

  localparam int unsigned CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    quo_q, quo_d;
  logic [VW-1:0]    rem_q, rem_d;
  logic [VW-1:0]    dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [VW:0]      shifted, diff;
  logic             ge;

  // shift next dividend bit into the partial remainder, subtract if it fits
  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = shifted >= {1'b0, dvs_q};
    rem_d   = ge ? diff[VW-1:0] : shifted[VW-1:0];
    quo_d   = {quo_q[DW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
      // one-cycle pulse after the last step
      done_q <= !start_i && busy_q && (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = quo_q;
  assign remainder_o  = rem_q;

endmodule

/* sv/two_gate_speed_trap.sv */
// top level of the two-gate speed trap: gate sequencing, tick counter,
// config registers and result register; depends on tgst_pkg, tgst_div
// and two_gate_speed_trap_macros.svh
//
//   channel   direction  handshake               payload
//   in        sink       in_valid_i / in_ready_o  start_gate_i, stop_gate_i
//   out       source     out_valid_o / out_ready_i outcome_o, elapsed_ms_o,
//                                                 speed_whole_o, speed_tenth_o,
//                                                 over_limit_o
//   cfg       sink       cfg_we_i                 cfg_idx_i, cfg_data_i
//
// a sample that gives no result, or a timeout result, is handled without leaving ST_SAMPLE
// a stop sample takes three serial divider passes of DW = max(TICK_WIDTH, 20)
// steps each, in ST_MS, ST_WHOLE and ST_TENTH
// the passes run on the single shared bit-serial divider; no input is taken meanwhile
// reset returns to idle with the register defaults and clears the alarm memory
// a stalled result register holds input back only for a sample that would
// itself give a result
`include "two_gate_speed_trap_macros.svh"

module two_gate_speed_trap import tgst_pkg::*; #(
  parameter int unsigned TICK_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // sample transaction
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                start_gate_i,
  input  logic                stop_gate_i,
  // result transaction
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                outcome_o,
  output logic [MS_W-1:0]     elapsed_ms_o,
  output logic [WHOLE_W-1:0]  speed_whole_o,
  output logic [TENTH_W-1:0]  speed_tenth_o,
  output logic                over_limit_o,
  // config writes
  input  logic                cfg_we_i,
  input  logic [CFG_AW-1:0]   cfg_idx_i,
  input  logic [CFG_DW-1:0]   cfg_data_i
);

  // divider width covers the tick count and ten times a remainder
  localparam int unsigned DW = (TICK_WIDTH > NUM_MIN_W) ? TICK_WIDTH : NUM_MIN_W;
  // compare width for tick count against the timeout
  localparam int unsigned CW = (TICK_WIDTH > TOUT_W) ? TICK_WIDTH : TOUT_W;

  typedef enum logic [1:0] {
    ST_SAMPLE,  // waiting for samples
    ST_MS,      // ticks / ticks_per_ms
    ST_WHOLE,   // distance * 1000 / ms
    ST_TENTH    // 10 * remainder / ms
  } state_e;

  state_e                state_q;
  logic                  timing_q;
  logic [TICK_WIDTH-1:0] tick_q;
  logic [WHOLE_W-1:0]    last_alarm_q;
  logic [MS_W-1:0]       ms_q;
  logic [WHOLE_W-1:0]    whole_q;

  // config registers
  logic [TOUT_W-1:0] timeout_q;
  logic [TPM_W-1:0]  tpm_q;
  logic [DIST_W-1:0] dist_q;
  logic [LIM_W-1:0]  limit_q;

  // result register
  logic               out_valid_q, out_valid_d;
  logic               outcome_q;
  logic [MS_W-1:0]    elapsed_q;
  logic [WHOLE_W-1:0] speed_whole_q;
  logic [TENTH_W-1:0] speed_tenth_q;
  logic               over_limit_q;

  // divider hookup
  div_stat_t         div_st;
  logic              div_start;
  logic [DW-1:0]     div_dividend;
  logic [MS_W-1:0]   div_divisor;
  logic [DW-1:0]     div_quo;
  logic [MS_W-1:0]   div_rem;

  logic                  in_fire;
  logic                  out_free;
  logic [TICK_WIDTH-1:0] tick_inc;
  logic                  timeout_hit;
  logic                  res_now;
  logic [TPM_W-1:0]      tpm_eff;
  logic [MS_W-1:0]       ms_sat;
  logic [MS_W-1:0]       ms_fix;
  logic [DW-1:0]         whole_num;
  logic [DW-1:0]         tenth_num;
  logic                  alarm;

  // saturating tick advance and timeout test on the advanced count
  assign tick_inc    = (tick_q == '1) ? tick_q : tick_q + TICK_WIDTH'(1);
  assign timeout_hit = CW'(tick_inc) >= CW'(timeout_q);

  // a sample gives a result if it times out or stops the measurement
  assign res_now  = timing_q && (timeout_hit || stop_gate_i);
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o = (state_q == ST_SAMPLE) && (out_free || !res_now);
  assign in_fire    = in_valid_i && in_ready_o;

  // zero ticks per ms counts as one
  assign tpm_eff = (tpm_q == '0) ? TPM_W'(1) : tpm_q;

  // elapsed ms saturates at the field width, zero is reported as one
  assign ms_sat = (|div_quo[DW-1:MS_W]) ? MS_MAX : div_quo[MS_W-1:0];
  assign ms_fix = (ms_sat == '0) ? MS_W'(1) : ms_sat;

  // whole speed is distance * 1000 / ms, tenth digit is 10 * remainder / ms
  assign whole_num = DW'(dist_q) * DW'(WHOLE_SCALE);
  assign tenth_num = DW'(div_rem) * DW'(TENTH_SCALE);

  assign alarm = (whole_q >= WHOLE_W'(limit_q)) && (whole_q != last_alarm_q);

  // result register fills on a timeout or a finished measurement,
  // drains on a result handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if ((in_fire && timing_q && timeout_hit) || ((state_q == ST_TENTH) && div_st.done)) begin
      out_valid_d = 1'b1;
    end
  end

  // divider operand selection per pass
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DW'(tick_inc);
    div_divisor  = MS_W'(tpm_eff);
    unique case (state_q)
      ST_SAMPLE: begin
        div_start = in_fire && timing_q && !timeout_hit && stop_gate_i;
      end
      ST_MS: begin
        div_start    = div_st.done;
        div_dividend = whole_num;
        div_divisor  = ms_fix;
      end
      ST_WHOLE: begin
        div_start    = div_st.done;
        div_dividend = tenth_num;
        div_divisor  = ms_q;
      end
      ST_TENTH: begin
        div_start = 1'b0;
      end
    endcase
  end

  tgst_div #(
    .DW (DW),
    .VW (MS_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .stat_o      (div_st),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TOUT_RST;
      tpm_q     <= TPM_RST;
      dist_q    <= DIST_RST;
      limit_q   <= LIM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TIMEOUT: timeout_q <= cfg_data_i[TOUT_W-1:0];
        CFG_TPM:     tpm_q     <= cfg_data_i[TPM_W-1:0];
        CFG_DIST:    dist_q    <= cfg_data_i[DIST_W-1:0];
        CFG_LIMIT:   limit_q   <= cfg_data_i[LIM_W-1:0];
      endcase
    end
  end

  // sequencer, session state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_SAMPLE;
      timing_q      <= 1'b0;
      tick_q        <= '0;
      last_alarm_q  <= '0;
      out_valid_q   <= 1'b0;
      ms_q          <= '0;
      whole_q       <= '0;
      outcome_q     <= 1'b0;
      elapsed_q     <= '0;
      speed_whole_q <= '0;
      speed_tenth_q <= '0;
      over_limit_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        ST_SAMPLE: begin
          if (in_fire) begin
            if (!timing_q) begin
              // idle: start gate arms timing, stop gate ignored
              if (start_gate_i) begin
                timing_q <= 1'b1;
                tick_q   <= '0;
              end
            end else begin
              tick_q <= tick_inc;
              if (timeout_hit) begin
                timing_q      <= 1'b0;
                outcome_q     <= 1'b1;
                elapsed_q     <= '0;
                speed_whole_q <= '0;
                speed_tenth_q <= '0;
                over_limit_q  <= 1'b0;
              end else if (stop_gate_i) begin
                timing_q <= 1'b0;
                state_q  <= ST_MS;
              end
            end
          end
        end
        ST_MS: begin
          if (div_st.done) begin
            ms_q    <= ms_fix;
            state_q <= ST_WHOLE;
          end
        end
        ST_WHOLE: begin
          if (div_st.done) begin
            whole_q <= div_quo[WHOLE_W-1:0];
            state_q <= ST_TENTH;
          end
        end
        ST_TENTH: begin
          if (div_st.done) begin
            outcome_q     <= 1'b0;
            elapsed_q     <= ms_q;
            speed_whole_q <= whole_q;
            speed_tenth_q <= div_quo[TENTH_W-1:0];
            over_limit_q  <= alarm;
            if (alarm) begin
              last_alarm_q <= whole_q;
            end
            state_q <= ST_SAMPLE;
          end
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign outcome_o     = outcome_q;
  assign elapsed_ms_o  = elapsed_q;
  assign speed_whole_o = speed_whole_q;
  assign speed_tenth_o = speed_tenth_q;
  assign over_limit_o  = over_limit_q;

  // no sample is taken while the divider works
  `TGST_ASSERT_IMP(a_no_input_while_div, clk_i, rst_ni, div_st.busy, !in_ready_o)
  // a finished measurement never lands on a pending result
  `TGST_ASSERT_IMP(a_slot_free_at_finish, clk_i, rst_ni,
    (state_q == ST_TENTH) && div_st.done, !out_valid_q)
  // and it shows up on the next cycle
  `TGST_ASSERT_NXT(a_result_after_finish, clk_i, rst_ni,
    (state_q == ST_TENTH) && div_st.done, out_valid_o && !outcome_o)
  // timeout results carry no measurement
  `TGST_ASSERT_IMP(a_timeout_fields_zero, clk_i, rst_ni, out_valid_o && outcome_o,
    (elapsed_ms_o == '0) && (speed_whole_o == '0) && !over_limit_o)

endmodule

/* verif/two_gate_speed_trap_test.sv */
// self-checking testbench for the two-gate speed trap: gate samples in,
// timing results out, checked against a cycle-free model of the trap
// depends on tgst_pkg and two_gate_speed_trap
`timescale 1ns / 100ps

module two_gate_speed_trap_test;
  import tgst_pkg::*;

  localparam int unsigned TICKS_W     = 16;
  localparam int unsigned HALF_PERIOD = 5;
  // cycles of silence on both channels before the run is called dead
  localparam int unsigned STALL_LIMIT = 3000;
  // three serial divider passes of max(TICKS_W, 20) steps each, with margin
  localparam int unsigned DRAIN_CYCLES = 100;
  // long receiver hold-off, so the result register backs up into the input
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_SAMPLES = 500;
  // idle ticks in the longer directed session
  localparam int unsigned LONG_TICKS = 199;

  typedef enum logic {
    MEASURED  = 1'b0,
    TIMED_OUT = 1'b1
  } outcome_e;

  typedef struct packed {
    outcome_e             outcome;
    logic [MS_W-1:0]      ms;
    logic [WHOLE_W-1:0]   whole;
    logic [TENTH_W-1:0]   tenth;
    logic                 alarm;
  } reading_t;

  // tracks the trap state, predicts each reading and checks what comes out
  class speed_reading_tracker;
    logic [TOUT_W-1:0]  timeout_ticks;
    logic [TPM_W-1:0]   ticks_per_ms;
    logic [DIST_W-1:0]  distance_cm;
    logic [LIM_W-1:0]   limit;
    bit                 timing;
    logic [TICKS_W-1:0] ticks;
    logic [WHOLE_W-1:0] alarmed_speed;
    reading_t           pending_readings[$];
    int unsigned        errors;
    int unsigned        readings_seen;

    function new();
      timeout_ticks = TOUT_RST;
      ticks_per_ms  = TPM_RST;
      distance_cm   = DIST_RST;
      limit         = LIM_RST;
      timing        = 1'b0;
      ticks         = '0;
      alarmed_speed = '0;
      errors        = 0;
      readings_seen = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DW-1:0] val);
      case (idx)
        CFG_TIMEOUT: timeout_ticks = val[TOUT_W-1:0];
        CFG_TPM:     ticks_per_ms  = val[TPM_W-1:0];
        CFG_DIST:    distance_cm   = val[DIST_W-1:0];
        CFG_LIMIT:   limit         = val[LIM_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_sample(logic start, logic stop);
      reading_t    r;
      int unsigned divisor;
      int unsigned ms;
      int unsigned tenths;
      int unsigned whole;
      if (!timing) begin
        // stop while idle is ignored, both gates only arm
        if (start) begin
          timing = 1'b1;
          ticks  = '0;
        end
        return;
      end
      if (ticks != '1) ticks++;
      if (ticks >= timeout_ticks) begin
        timing = 1'b0;
        r = '0;
        r.outcome = TIMED_OUT;
        pending_readings.push_back(r);
        return;
      end
      if (!stop) return;
      divisor = (ticks_per_ms == 0) ? 1 : ticks_per_ms;
      ms = ticks / divisor;
      if (ms == 0) ms = 1;
      if (ms > MS_MAX) ms = MS_MAX;
      tenths = (distance_cm * 10000) / ms;
      whole  = tenths / 10;
      r.outcome = MEASURED;
      r.ms      = ms[MS_W-1:0];
      r.whole   = whole[WHOLE_W-1:0];
      r.tenth   = 4'(tenths % 10);
      r.alarm   = (whole >= limit) && (r.whole != alarmed_speed);
      if (r.alarm) alarmed_speed = r.whole;
      timing = 1'b0;
      pending_readings.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      readings_seen++;
      if (pending_readings.size() == 0) begin
        $error("reading with no sample to explain it: outcome %0d ms %0d speed %0d",
               got.outcome, got.ms, got.whole);
        errors++;
        return;
      end
      want = pending_readings.pop_front();
      compare_field("outcome", want.outcome, got.outcome);
      compare_field("elapsed_ms", want.ms, got.ms);
      compare_field("speed_whole", want.whole, got.whole);
      compare_field("speed_tenth", want.tenth, got.tenth);
      compare_field("over_limit", want.alarm, got.alarm);
    endfunction

    function int unsigned pending();
      return pending_readings.size();
    endfunction
  endclass

  // every block input is known from time zero
  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic               start_gate_i = 1'b0;
  logic               stop_gate_i  = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic               outcome_o;
  logic [MS_W-1:0]    elapsed_ms_o;
  logic [WHOLE_W-1:0] speed_whole_o;
  logic [TENTH_W-1:0] speed_tenth_o;
  logic               over_limit_o;
  logic               cfg_we_i     = 1'b0;
  logic [CFG_AW-1:0]  cfg_idx_i    = '0;
  logic [CFG_DW-1:0]  cfg_data_i   = '0;

  speed_reading_tracker tracker = new();

  // idle percentages per phase for sender and receiver, zero means steady
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          hold_req    = 1'b0;
  int unsigned random_samples = 0;
  int unsigned quiet_cycles   = 0;

  two_gate_speed_trap #(
    .TICK_WIDTH(TICKS_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .start_gate_i (start_gate_i),
    .stop_gate_i  (stop_gate_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .outcome_o    (outcome_o),
    .elapsed_ms_o (elapsed_ms_o),
    .speed_whole_o(speed_whole_o),
    .speed_tenth_o(speed_tenth_o),
    .over_limit_o (over_limit_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // monitor at the rising edge: check readings first, then log samples,
  // and keep the stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        tracker.check_reading('{outcome: outcome_e'(outcome_o), ms: elapsed_ms_o,
                                whole: speed_whole_o, tenth: speed_tenth_o,
                                alarm: over_limit_o});
      end
      if (in_valid_i && in_ready_o) begin
        tracker.take_sample(start_gate_i, stop_gate_i);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $error("no transaction for %0d cycles", STALL_LIMIT);
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    int unsigned burst;
    burst = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        // hold-off counted here while the sender keeps offering samples
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      if (burst == 0 && rx_idle_pct != 0 && $urandom_range(1, 100) <= rx_idle_pct) begin
        burst = $urandom_range(1, 8);
      end
      if (burst != 0) begin
        out_ready_i = 1'b0;
        burst--;
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  // offer one sample and return at the falling edge after it is taken;
  // valid stays high so back-to-back samples need no extra edge
  task automatic send_sample(input logic start, input logic stop);
    int unsigned gap;
    if (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct) begin
      gap = $urandom_range(1, 8);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    start_gate_i = start;
    stop_gate_i  = stop;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DW-1:0] val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    tracker.set_reg(idx, val);
  endtask

  // drop valid, wait for every reading, then let the divider finish
  task automatic settle();
    in_valid_i = 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // stray samples, arm, ticks with random start noise, then stop;
  // sometimes runs into the timeout, sometimes stops early
  task automatic run_session(input int unsigned max_ticks);
    int unsigned noise;
    int unsigned span;
    noise = $urandom_range(0, 2);
    repeat (noise) send_sample(1'b0, 1'($urandom_range(0, 1)));
    send_sample(1'b1, 1'($urandom_range(0, 1)));
    span = $urandom_range(0, max_ticks);
    if ($urandom_range(0, 5) == 0 && tracker.timeout_ticks < 400) begin
      span = tracker.timeout_ticks + $urandom_range(0, 2);
    end
    repeat (span) send_sample(1'($urandom_range(0, 1)), $urandom_range(0, 15) == 0);
    send_sample(1'($urandom_range(0, 1)), 1'b1);
    random_samples += span + 2;
  endtask

  task automatic pick_settings();
    case ($urandom_range(0, 3))
      0, 1: begin
        // small distance and divisor keep speeds around the alarm limit
        write_reg(CFG_TIMEOUT, CFG_DW'($urandom_range(20, 300)));
        write_reg(CFG_TPM, CFG_DW'($urandom_range(1, 2)));
        write_reg(CFG_DIST, CFG_DW'($urandom_range(1, 3)));
        write_reg(CFG_LIMIT, CFG_DW'($urandom_range(0, 127)));
      end
      2: begin
        write_reg(CFG_TIMEOUT, CFG_DW'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4)
                                                                   : $urandom_range(0, 16'hFFFF)));
        write_reg(CFG_TPM, CFG_DW'($urandom_range(0, 255)));
        write_reg(CFG_DIST, CFG_DW'($urandom_range(0, 255)));
        write_reg(CFG_LIMIT, CFG_DW'($urandom_range(0, 127)));
      end
      default: begin
        // one register with full-width data, upper bits must be dropped
        write_reg(cfg_idx_e'($urandom_range(0, 3)), CFG_DW'($urandom_range(0, 16'hFFFF)));
      end
    endcase
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned sessions;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: gates out of turn, zero ms taken as one,
    // alarm raised once then held for a repeated speed
    send_sample(1'b0, 1'b1);
    send_sample(1'b0, 1'b0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b0);
    send_sample(1'b0, 1'b1);
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b1);
    settle();

    // zero timeout expires on the first tick, zero divisor, limit above 99
    write_reg(CFG_TIMEOUT, 16'd0);
    write_reg(CFG_TPM, 16'd0);
    write_reg(CFG_DIST, 16'd255);
    write_reg(CFG_LIMIT, 16'd127);
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b0);
    settle();

    // timeout wins over a stop on the same tick
    write_reg(CFG_TIMEOUT, 16'd1);
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b1);
    settle();

    // fastest speed: largest distance over one ms
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b1);
    settle();

    write_reg(CFG_TPM, 16'd255);
    write_reg(CFG_DIST, 16'd1);
    write_reg(CFG_LIMIT, 16'd0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b0);
    send_sample(1'b0, 1'b1);
    settle();

    // a longer session run without gaps: a few hundred ms elapsed
    write_reg(CFG_TPM, 16'd1);
    send_sample(1'b1, 1'b0);
    repeat (LONG_TICKS) send_sample(1'b0, 1'b0);
    send_sample(1'b0, 1'b1);
    settle();

    // random phases, each with fresh settings and idle rates
    phase = 0;
    while (random_samples < RANDOM_SAMPLES) begin
      pick_settings();
      if (random_samples >= RANDOM_SAMPLES - 100) begin
        // closing stretch runs steady
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        rx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      end
      if (phase == 0) hold_req = 1'b1;
      sessions = $urandom_range(2, 8);
      repeat (sessions) run_session((phase == 0) ? 4 : 60);
      settle();
      phase++;
    end

    // closing stretch with no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    pick_settings();
    repeat (3) run_session(30);
    settle();

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
